>>> hdl/bcbf_pkg.sv
package bcbf_pkg;

    localparam int SLOTS_PER_BIN  = 64;
    localparam int MAX_BINS       = 1024;
    localparam int MAX_CATEGORIES = 4;
    localparam int COUNTER_BITS   = 16;

    // slot index width: largest b with 2^b <= SLOTS_PER_BIN
    localparam int SLOT_W  = $clog2(SLOTS_PER_BIN + 1) - 1;
    localparam int BIN_W   = $clog2(MAX_BINS);
    localparam int CAT_W   = 2;
    localparam int ADDR_W  = CAT_W + BIN_W + SLOT_W;
    localparam int DEPTH   = 1 << ADDR_W;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 64;
    localparam int TOTAL_W  = 18;
    localparam int PREV_W   = 16;
    localparam int NB_W     = 11;
    localparam int NP_W     = 4;
    localparam int NC_W     = 3;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 2;
    localparam int PROBE_W  = 3;

    localparam logic [OP_W-1:0] OP_ADD       = 2'd0;
    localparam logic [OP_W-1:0] OP_COUNT     = 2'd1;
    localparam logic [OP_W-1:0] OP_COUNT_ALL = 2'd2;
    localparam logic [OP_W-1:0] OP_RESERVED  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_BINS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROBES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CATS = 2'd2;

    typedef enum logic [4:0] {
        DP_NOP, DP_CLEAR, DP_LOAD, DP_MUL, DP_ROT, DP_XS, DP_PRE, DP_PREB,
        DP_SWAP, DP_FIN1, DP_FIN2, DP_DIV, DP_RD, DP_INC, DP_MINUP, DP_ACC, DP_EMIT
    } t_dp_op;

    typedef enum logic [1:0] {K_C1, K_C2, K_F1, K_F2} t_mul_k;

    typedef struct packed {
        t_dp_op               op;
        t_mul_k               mk;
        logic [1:0]           phase;
        logic [PROBE_W-1:0]   probe;
        logic [CAT_W-1:0]     cat;
    } t_dp_cmd;

    typedef struct packed {
        logic                 clear_done;
        logic [OP_W-1:0]      op;
        logic                 bad;
        logic [CAT_W-1:0]     cat;
        logic [PROBE_W-1:0]   np_last;
        logic [CAT_W-1:0]     nc_last;
        logic                 out_full;
    } t_dp_status;

    function automatic logic [63:0] mul_k(input t_mul_k sel);
        logic [63:0] k;
        unique case (sel)
            K_C1:    k = 64'h87c37b91114253d5;
            K_C2:    k = 64'h4cf5ad432745937f;
            K_F1:    k = 64'hff51afd7ed558ccd;
            default: k = 64'hc4ceb9fe1a85ec53;
        endcase
        return k;
    endfunction

endpackage

>>> hdl/bcbf_if.sv
interface bcbf_req_if import bcbf_pkg::*; ;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [KEY_W-1:0]   kmer;
    logic [CAT_W-1:0]   category;

    modport source(output valid, operation, kmer, category, input ready);
    modport sink(input valid, operation, kmer, category, output ready);
endinterface

interface bcbf_rsp_if import bcbf_pkg::*; ;
    logic               valid;
    logic               ready;
    logic [TOTAL_W-1:0] tally;
    logic [PREV_W-1:0]  peak;
    logic               status;

    modport source(output valid, tally, peak, status, input ready);
    modport sink(input valid, tally, peak, status, output ready);
endinterface

>>> hdl/bcbf_ctl.sv
module bcbf_ctl import bcbf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_CHECK = 5'd2;
    localparam logic [4:0] S_M1    = 5'd3;
    localparam logic [4:0] S_ROT   = 5'd4;
    localparam logic [4:0] S_M2    = 5'd5;
    localparam logic [4:0] S_PRE   = 5'd6;
    localparam logic [4:0] S_PREB  = 5'd7;
    localparam logic [4:0] S_X1    = 5'd8;
    localparam logic [4:0] S_F1    = 5'd9;
    localparam logic [4:0] S_X2    = 5'd10;
    localparam logic [4:0] S_F2    = 5'd11;
    localparam logic [4:0] S_X3    = 5'd12;
    localparam logic [4:0] S_SWAP  = 5'd13;
    localparam logic [4:0] S_FIN1  = 5'd14;
    localparam logic [4:0] S_FIN2  = 5'd15;
    localparam logic [4:0] S_DIV   = 5'd16;
    localparam logic [4:0] S_RD    = 5'd17;
    localparam logic [4:0] S_UPD   = 5'd18;
    localparam logic [4:0] S_ACC   = 5'd19;
    localparam logic [4:0] S_EMIT  = 5'd20;

    logic [4:0]       r_state, n_state;
    logic [5:0]       r_cnt, n_cnt;
    logic [CAT_W-1:0] r_cat, n_cat;
    logic             r_pass, n_pass;
    logic             w_mul_last;
    logic             w_reserved;

    assign w_mul_last = (r_cnt[1:0] == 2'd2);
    assign w_reserved = (i_status.op != OP_ADD) && (i_status.op != OP_COUNT)
                        && (i_status.op != OP_COUNT_ALL);
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_cat       = r_cat;
        n_pass      = r_pass;
        o_cmd.op    = DP_NOP;
        o_cmd.mk    = K_C1;
        o_cmd.phase = r_cnt[1:0];
        o_cmd.probe = r_cnt[PROBE_W-1:0];
        o_cmd.cat   = r_cat;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = DP_CLEAR;
                if (i_status.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = DP_LOAD;
                    n_pass   = 1'b0;
                    n_cnt    = '0;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.bad || w_reserved) n_state = S_EMIT;
                else                            n_state = S_M1;
            end
            S_M1: begin
                o_cmd.op = DP_MUL;
                o_cmd.mk = K_C1;
                n_cnt    = w_mul_last ? '0 : r_cnt + 6'd1;
                if (w_mul_last) n_state = S_ROT;
            end
            S_ROT: begin
                o_cmd.op = DP_ROT;
                n_state  = S_M2;
            end
            S_M2: begin
                o_cmd.op = DP_MUL;
                o_cmd.mk = K_C2;
                n_cnt    = w_mul_last ? '0 : r_cnt + 6'd1;
                if (w_mul_last) n_state = S_PRE;
            end
            S_PRE: begin
                o_cmd.op = DP_PRE;
                n_state  = S_PREB;
            end
            S_PREB: begin
                o_cmd.op = DP_PREB;
                n_state  = S_X1;
            end
            S_X1: begin
                o_cmd.op = DP_XS;
                n_state  = S_F1;
            end
            S_F1: begin
                o_cmd.op = DP_MUL;
                o_cmd.mk = K_F1;
                n_cnt    = w_mul_last ? '0 : r_cnt + 6'd1;
                if (w_mul_last) n_state = S_X2;
            end
            S_X2: begin
                o_cmd.op = DP_XS;
                n_state  = S_F2;
            end
            S_F2: begin
                o_cmd.op = DP_MUL;
                o_cmd.mk = K_F2;
                n_cnt    = w_mul_last ? '0 : r_cnt + 6'd1;
                if (w_mul_last) n_state = S_X3;
            end
            S_X3: begin
                o_cmd.op = DP_XS;
                n_state  = r_pass ? S_FIN1 : S_SWAP;
            end
            S_SWAP: begin
                // second finalizer pass works on the high word
                o_cmd.op = DP_SWAP;
                n_pass   = 1'b1;
                n_state  = S_X1;
            end
            S_FIN1: begin
                o_cmd.op = DP_FIN1;
                n_state  = S_FIN2;
            end
            S_FIN2: begin
                o_cmd.op = DP_FIN2;
                n_cnt    = '0;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = DP_DIV;
                n_cnt    = r_cnt + 6'd1;
                if (&r_cnt) begin
                    n_cnt   = '0;
                    n_cat   = (i_status.op == OP_COUNT_ALL) ? '0 : i_status.cat;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.op = DP_RD;
                n_state  = S_UPD;
            end
            S_UPD: begin
                o_cmd.op = (i_status.op == OP_ADD) ? DP_INC : DP_MINUP;
                if (r_cnt[PROBE_W-1:0] == i_status.np_last) begin
                    n_cnt   = '0;
                    n_state = (i_status.op == OP_ADD) ? S_EMIT : S_ACC;
                end else begin
                    n_cnt   = r_cnt + 6'd1;
                    n_state = S_RD;
                end
            end
            S_ACC: begin
                o_cmd.op = DP_ACC;
                if (i_status.op == OP_COUNT || r_cat == i_status.nc_last) begin
                    n_state = S_EMIT;
                end else begin
                    n_cat   = r_cat + 1'b1;
                    n_state = S_RD;
                end
            end
            S_EMIT: begin
                if (!i_status.out_full) begin
                    o_cmd.op = DP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_cat   <= '0;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_cat   <= n_cat;
            r_pass  <= n_pass;
        end
    end

endmodule

>>> hdl/bcbf_dp.sv
module bcbf_dp import bcbf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [OP_W-1:0]      i_operation,
    input  logic [KEY_W-1:0]     i_kmer,
    input  logic [CAT_W-1:0]     i_category,
    bcbf_rsp_if.source           o_rsp
);

    localparam logic [NB_W-1:0]  NB_MAX   = NB_W'(MAX_BINS);
    localparam logic [NC_W-1:0]  NC_MAX   = NC_W'(MAX_CATEGORIES);
    localparam logic [NP_W-1:0]  NP_MAX   = NP_W'(8);

    logic [NB_W-1:0]          r_num_bins;
    logic [NP_W-1:0]          r_probes;
    logic [NC_W-1:0]          r_num_cats;
    logic [NB_W-1:0]          w_nb;
    logic [NP_W-1:0]          w_np;
    logic [NC_W-1:0]          w_nc;

    logic [OP_W-1:0]          r_op;
    logic [CAT_W-1:0]         r_cat;
    logic                     r_bad;
    logic [63:0]              r_w, r_a, r_b, r_acc;
    logic [NB_W-1:0]          r_rem;
    logic [COUNTER_BITS-1:0]  r_min;
    logic [TOTAL_W-1:0]       r_total;
    logic [PREV_W-1:0]        r_prev;
    logic [ADDR_W-1:0]        r_clr_addr;

    logic [COUNTER_BITS-1:0]  r_mem [DEPTH];
    logic [COUNTER_BITS-1:0]  r_rdata;

    logic                     r_out_valid;
    logic [TOTAL_W-1:0]       r_out_total;
    logic [PREV_W-1:0]        r_out_prev;
    logic                     r_out_status;

    logic [63:0]              w_k;
    logic [31:0]              w_mx, w_my;
    logic [63:0]              w_mp;
    logic [63:0]              w_pre;
    logic [NB_W:0]            w_trial;
    logic [7:0]               w_byte;
    logic [ADDR_W-1:0]        w_addr;
    logic                     w_we, w_re;
    logic [COUNTER_BITS-1:0]  w_wdata;
    logic [TOTAL_W:0]         w_sum;
    logic [CAT_W-1:0]         w_nc_last;

    // clamp configuration to legal ranges
    assign w_nb = (r_num_bins == '0) ? NB_W'(1) : (r_num_bins > NB_MAX ? NB_MAX : r_num_bins);
    assign w_np = (r_probes == '0) ? NP_W'(1) : (r_probes > NP_MAX ? NP_MAX : r_probes);
    assign w_nc = (r_num_cats == '0) ? NC_W'(1) : (r_num_cats > NC_MAX ? NC_MAX : r_num_cats);
    assign w_nc_last = CAT_W'(w_nc - NC_W'(1));

    // 64x64 low product built from three 32x32 partial products
    assign w_k = mul_k(i_cmd.mk);
    always_comb begin
        case (i_cmd.phase)
            2'd0:    begin w_mx = r_w[31:0];  w_my = w_k[31:0];  end
            2'd1:    begin w_mx = r_w[31:0];  w_my = w_k[63:32]; end
            default: begin w_mx = r_w[63:32]; w_my = w_k[31:0];  end
        endcase
    end
    assign w_mp = w_mx * w_my;

    assign w_pre   = (r_w ^ 64'd8) + 64'd8;
    assign w_trial = {r_rem, r_a[63]};
    assign w_byte  = 8'(r_b >> {i_cmd.probe, 3'b000});
    assign w_addr  = (i_cmd.op == DP_CLEAR) ? r_clr_addr
                   : {i_cmd.cat, r_rem[BIN_W-1:0], w_byte[SLOT_W-1:0]};
    assign w_we    = (i_cmd.op == DP_CLEAR) || (i_cmd.op == DP_INC);
    assign w_re    = (i_cmd.op == DP_RD);
    assign w_wdata = (i_cmd.op == DP_CLEAR) ? '0
                   : ((&r_rdata) ? r_rdata : r_rdata + 1'b1);
    assign w_sum   = {1'b0, r_total} + (TOTAL_W + 1)'(r_min);

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_addr] <= w_wdata;
        if (w_re) r_rdata <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_bins <= NB_W'(1024);
            r_probes   <= NP_W'(4);
            r_num_cats <= NC_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_NUM_BINS: r_num_bins <= i_cfg_data[NB_W-1:0];
                REG_PROBES:   r_probes   <= i_cfg_data[NP_W-1:0];
                REG_NUM_CATS: r_num_cats <= i_cfg_data[NC_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == DP_CLEAR) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cmd.op == DP_EMIT)  r_out_valid <= 1'b1;
            else if (o_rsp.ready)     r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                r_op    <= i_operation;
                r_cat   <= i_category;
                r_bad   <= ((i_operation == OP_ADD) || (i_operation == OP_COUNT))
                           && (i_category > w_nc_last);
                r_w     <= i_kmer;
                r_min   <= '1;
                r_total <= '0;
                r_prev  <= '0;
            end
            DP_MUL: begin
                case (i_cmd.phase)
                    2'd0:    r_acc <= w_mp;
                    2'd1:    r_acc <= r_acc + {w_mp[31:0], 32'd0};
                    default: r_w   <= r_acc + {w_mp[31:0], 32'd0};
                endcase
            end
            DP_ROT:  r_w <= {r_w[32:0], r_w[63:33]};
            DP_XS:   r_w <= r_w ^ {33'd0, r_w[63:33]};
            DP_PRE: begin
                r_w <= w_pre;
                r_a <= w_pre;
            end
            DP_PREB: r_b <= r_a + 64'd8;
            DP_SWAP: begin
                r_a <= r_w;
                r_w <= r_b;
            end
            DP_FIN1: begin
                r_b <= r_w;
                r_a <= r_a + r_w;
            end
            DP_FIN2: begin
                r_b   <= r_b + r_a;
                r_rem <= '0;
            end
            DP_DIV: begin
                // restoring remainder, one dividend bit per step
                r_a <= {r_a[62:0], 1'b0};
                if (w_trial >= {1'b0, w_nb}) r_rem <= NB_W'(w_trial - {1'b0, w_nb});
                else                         r_rem <= NB_W'(w_trial);
            end
            DP_MINUP: if (r_rdata < r_min) r_min <= r_rdata;
            DP_ACC: begin
                r_total <= w_sum[TOTAL_W] ? '1 : w_sum[TOTAL_W-1:0];
                if (PREV_W'(r_min) > r_prev) r_prev <= PREV_W'(r_min);
                r_min   <= '1;
            end
            DP_EMIT: begin
                r_out_total  <= r_total;
                r_out_prev   <= r_prev;
                r_out_status <= r_bad;
            end
            default: ;
        endcase
    end

    assign o_status.clear_done = &r_clr_addr;
    assign o_status.op         = r_op;
    assign o_status.bad        = r_bad;
    assign o_status.cat        = r_cat;
    assign o_status.np_last    = PROBE_W'(w_np - NP_W'(1));
    assign o_status.nc_last    = w_nc_last;
    assign o_status.out_full   = r_out_valid && !o_rsp.ready;

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.tally  = r_out_total;
    assign o_rsp.peak   = r_out_prev;
    assign o_rsp.status = r_out_status;

endmodule

>>> hdl/blocked_counting_bloom_filter.sv
// Hash uses one shared 32x32 multiplier; bin select is a 64-step serial remainder;
//   each probe takes a read and then an update step on the counter RAM.
// One transaction is processed at a time; the next is taken while a result waits.
// Reset: synchronous, active low; then a pass zeroes all 262144 counter RAM words, no input taken.
module blocked_counting_bloom_filter import bcbf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    bcbf_req_if.sink             i_req,
    bcbf_rsp_if.source           o_rsp
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;

    assign i_req.ready = w_in_ready;

    bcbf_ctl u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    bcbf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_operation (i_req.operation),
        .i_kmer      (i_req.kmer),
        .i_category  (i_req.category),
        .o_rsp       (o_rsp)
    );

endmodule

>>> hdl/bcbf_checker.sv
module bcbf_checker import bcbf_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [TOTAL_W-1:0] i_total,
    input logic [PREV_W-1:0]  i_prev,
    input logic               i_status
);

    logic [1:0] r_pend;
    logic       w_in_acc, w_out_acc;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    // count transactions accepted but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pend <= '0;
        else          r_pend <= r_pend + 2'(w_in_acc) - 2'(w_out_acc);
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_total)
        && $stable(i_prev) && $stable(i_status))
        else $error("result dropped or changed while stalled");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pend != 2'd0)
        else $error("result without pending transaction");

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 2'd2)
        else $error("too many transactions in flight");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status |-> i_total == '0 && i_prev == '0)
        else $error("rejected transaction returned counts");

    a_prev_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> TOTAL_W'(i_prev) <= i_total)
        else $error("largest plane count exceeds total");

endmodule

bind blocked_counting_bloom_filter bcbf_checker u_bcbf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_total     (o_rsp.tally),
    .i_prev      (o_rsp.peak),
    .i_status    (o_rsp.status)
);

>>> bench/tb_checker.sv
module tb_checker import bcbf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    bcbf_req_if                  req,
    bcbf_rsp_if                  rsp,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_adds,
    output int                   o_queries,
    output int                   o_rejects
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [TOTAL_W-1:0] total;
        logic [PREV_W-1:0]  prev;
        logic               status;
    } t_answer;

    localparam logic [63:0] MIX_C1 = 64'h87c37b91114253d5;
    localparam logic [63:0] MIX_C2 = 64'h4cf5ad432745937f;
    localparam logic [63:0] FIN_C1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FIN_C2 = 64'hc4ceb9fe1a85ec53;
    localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

    logic [COUNTER_BITS-1:0] counters [DEPTH];
    logic [NB_W-1:0] bins_reg;
    logic [NP_W-1:0] probes_reg;
    logic [NC_W-1:0] planes_reg;
    t_answer answers_due [$];

    function automatic logic [63:0] avalanche(input logic [63:0] v);
        logic [63:0] k;
        k = v ^ (v >> 33);
        k = k * FIN_C1;
        k = k ^ (k >> 33);
        k = k * FIN_C2;
        return k ^ (k >> 33);
    endfunction

    function automatic void murmur_key(input logic [63:0] key,
                                       output logic [63:0] h1, output logic [63:0] h2);
        logic [63:0] k, a, b;
        k = key * MIX_C1;
        k = (k << 31) | (k >> 33);
        k = k * MIX_C2;
        a = k ^ 64'd8;
        b = 64'd8;
        a = a + b;
        b = b + a;
        a = avalanche(a);
        b = avalanche(b);
        a = a + b;
        b = b + a;
        h1 = a;
        h2 = b;
    endfunction

    function automatic int eff_bins();
        return bins_reg == 0 ? 1 : (bins_reg > MAX_BINS ? MAX_BINS : int'(bins_reg));
    endfunction

    function automatic int eff_probes();
        return probes_reg == 0 ? 1 : (probes_reg > 8 ? 8 : int'(probes_reg));
    endfunction

    function automatic int eff_planes();
        return planes_reg == 0 ? 1 :
               (planes_reg > MAX_CATEGORIES ? MAX_CATEGORIES : int'(planes_reg));
    endfunction

    // address of probe i for the key in plane cat
    function automatic int probe_addr(input logic [63:0] key, input int cat, input int i);
        logic [63:0] h1, h2;
        int bin, slot;
        murmur_key(key, h1, h2);
        bin  = int'(h1 % 64'(eff_bins()));
        slot = int'((h2 >> (8 * i)) & 64'hFF) & ((1 << SLOT_W) - 1);
        return ((cat * MAX_BINS + bin) * SLOTS_PER_BIN + slot) % DEPTH;
    endfunction

    function automatic int plane_minimum(input logic [63:0] key, input int cat);
        int best, v;
        best = int'(CNT_MAX);
        for (int i = 0; i < eff_probes(); i++) begin
            v = int'(counters[probe_addr(key, cat, i)]);
            if (v < best) best = v;
        end
        return best;
    endfunction

    // apply one transaction to the shadow store and return its answer
    function automatic t_answer apply_item(input logic [OP_W-1:0] op,
                                           input logic [63:0] key, input logic [CAT_W-1:0] cat);
        t_answer ans;
        int sum, top, v, a;
        ans = '{total: '0, prev: '0, status: 1'b0};
        sum = 0;
        top = 0;
        if (op == OP_ADD || op == OP_COUNT) begin
            if (int'(cat) >= eff_planes()) begin
                ans.status = 1'b1;
                o_rejects++;
            end else if (op == OP_ADD) begin
                o_adds++;
                for (int i = 0; i < eff_probes(); i++) begin
                    a = probe_addr(key, int'(cat), i);
                    if (counters[a] != CNT_MAX) counters[a] = counters[a] + 1'b1;
                end
            end else begin
                o_queries++;
                v = plane_minimum(key, int'(cat));
                ans.total = TOTAL_W'(v);
                ans.prev  = PREV_W'(v);
            end
        end else if (op == OP_COUNT_ALL) begin
            o_queries++;
            for (int c = 0; c < eff_planes(); c++) begin
                v = plane_minimum(key, c);
                sum += v;
                if (v > top) top = v;
            end
            ans.total = sum > 262143 ? '1 : TOTAL_W'(sum);
            ans.prev  = top > 65535 ? '1 : PREV_W'(top);
        end
        return ans;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_adds = 0;
        o_queries = 0;
        o_rejects = 0;
        foreach (counters[i]) counters[i] = '0;
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            foreach (counters[i]) counters[i] = '0;
            bins_reg   = NB_W'(MAX_BINS);
            probes_reg = NP_W'(4);
            planes_reg = NC_W'(1);
            answers_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_NUM_BINS: bins_reg   = i_cfg_data[NB_W-1:0];
                    REG_PROBES:   probes_reg = i_cfg_data[NP_W-1:0];
                    REG_NUM_CATS: planes_reg = i_cfg_data[NC_W-1:0];
                    default: ;
                endcase
            end
            if (rsp.valid && rsp.ready) begin
                if (answers_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("[%0t] unexpected result total=%0d prev=%0d status=%0d",
                                 $realtime, rsp.tally, rsp.peak, rsp.status);
                end else begin
                    want = answers_due.pop_front();
                    if (rsp.tally !== want.total || rsp.peak !== want.prev
                            || rsp.status !== want.status) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"[%0t] mismatch: exp total=%0d prev=%0d status=%0d,",
                                      " got total=%0d prev=%0d status=%0d"},
                                     $realtime, want.total, want.prev, want.status,
                                     rsp.tally, rsp.peak, rsp.status);
                    end
                end
            end
            if (req.valid && req.ready)
                answers_due.push_back(apply_item(req.operation, req.kmer, req.category));
        end
        o_pending = answers_due.size();
    end

    final begin
        if (answers_due.size() != 0) $display("%0d results never arrived", answers_due.size());
    end
endmodule

>>> bench/tb_top.sv
module tb_top import bcbf_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int DRAIN_CYCLES = 200;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    int fail_count, pending, n_adds, n_queries, n_rejects;
    int send_idle_pct, rsp_stall_pct;
    int cycles;
    logic [63:0] key_pool [16];

    bcbf_req_if req();
    bcbf_rsp_if rsp();

    blocked_counting_bloom_filter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_req(req.sink), .o_rsp(rsp.source)
    );

    tb_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .req(req), .rsp(rsp), .o_fail_count(fail_count), .o_pending(pending),
        .o_adds(n_adds), .o_queries(n_queries), .o_rejects(n_rejects)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // randomize the result side's back-pressure
    always @(negedge i_clk) rsp.ready = ($urandom_range(99) >= rsp_stall_pct);

    task automatic send_item(input logic [OP_W-1:0] op, input logic [63:0] key,
                             input logic [CAT_W-1:0] cat);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            req.valid = 1'b0;
        end
        @(negedge i_clk);
        req.valid = 1'b1;
        req.operation = op;
        req.kmer = key;
        req.category = cat;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        req.valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = CFG_W'(value);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic run_random(input int count, input int planes);
        logic [OP_W-1:0] op;
        logic [63:0] key;
        logic [CAT_W-1:0] cat;
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            op = pick < 45 ? OP_ADD : pick < 70 ? OP_COUNT
               : pick < 95 ? OP_COUNT_ALL : OP_RESERVED;
            // reuse a small pool of keys so counters climb and queries hit
            key = ($urandom_range(99) < 70) ? key_pool[$urandom_range(15)]
                                            : {$urandom, $urandom};
            cat = ($urandom_range(99) < 85) ? CAT_W'($urandom_range(planes - 1))
                                            : CAT_W'($urandom_range(3));
            send_item(op, key, cat);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        req.valid = 1'b0;
        req.operation = '0;
        req.kmer = '0;
        req.category = '0;
        rsp.ready = 1'b0;
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: default registers, key extremes, every op, bad category, reserved op
        send_item(OP_COUNT, 64'h0, 2'd0);
        send_item(OP_ADD, 64'h0, 2'd0);
        send_item(OP_ADD, 64'h0, 2'd0);
        send_item(OP_COUNT, 64'h0, 2'd0);
        send_item(OP_COUNT_ALL, 64'h0, 2'd0);
        send_item(OP_ADD, '1, 2'd0);
        send_item(OP_COUNT, '1, 2'd0);
        send_item(OP_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 2'd0);
        send_item(OP_ADD, 64'h5555_5555_5555_5555, 2'd0);
        send_item(OP_COUNT_ALL, 64'hAAAA_AAAA_AAAA_AAAA, 2'd3);
        send_item(OP_ADD, 64'h1234, 2'd1);
        send_item(OP_COUNT, 64'h1234, 2'd3);
        send_item(OP_RESERVED, '1, 2'd3);
        send_item(OP_RESERVED, 64'h0, 2'd0);
        drain();

        // several settings, extremes and out-of-range values among them
        for (int ph = 0; ph < 6; ph++) begin
            int bins_v, probes_v, cats_v, planes;
            case (ph)
                0: begin bins_v = 1;    probes_v = 8;  cats_v = 4; end
                1: begin bins_v = 2047; probes_v = 0;  cats_v = 0; end
                2: begin bins_v = 0;    probes_v = 15; cats_v = 7; end
                3: begin bins_v = 1024; probes_v = 1;  cats_v = 2; end
                4: begin bins_v = 3;    probes_v = 5;  cats_v = 3; end
                default: begin
                    bins_v = $urandom_range(1, 64);
                    probes_v = $urandom_range(1, 8);
                    cats_v = $urandom_range(1, 4);
                end
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
                1: begin send_idle_pct = 73; rsp_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rsp_stall_pct = 73; end
                default: begin send_idle_pct = 22; rsp_stall_pct = 22; end
            endcase
            write_reg(REG_NUM_BINS, bins_v);
            write_reg(REG_PROBES, probes_v);
            write_reg(REG_NUM_CATS, cats_v);
            planes = cats_v < 1 ? 1 : (cats_v > 4 ? 4 : cats_v);
            run_random(148, planes);
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d adds, %0d queries, %0d rejected categories over 7 settings",
                 n_adds, n_queries, n_rejects);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("FAILURE");
        end
        $finish;
    end
endmodule
